FILE: rtl/iagg_pkg.sv
// ----------------------------------------------------------------------------
// In-network reduce aggregator package
// Item types, status and operation codes shared by the aggregator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iagg_pkg;

    // Number of data words carried by one item.
    localparam int WORDS = 4;
    // Width of a port number inside the block; covers up to sixteen ports.
    localparam int TGT_W = 4;

    typedef enum logic [2:0] {
        STATUS_RELEASED  = 3'd0,
        STATUS_WRONG_DIR = 3'd1,
        STATUS_CONFLICT  = 3'd2,
        STATUS_DUPLICATE = 3'd3,
        STATUS_DEST      = 3'd4,
        STATUS_OP        = 3'd5,
        STATUS_LENGTH    = 3'd6,
        STATUS_SELF      = 3'd7
    } iagg_status_t;

    typedef enum logic [1:0] {
        OP_SUM  = 2'd0,
        OP_PROD = 2'd1,
        OP_MIN  = 2'd2,
        OP_MAX  = 2'd3
    } iagg_op_t;

    typedef struct packed {
        logic        [2:0]  source_port;
        logic        [9:0]  dest_node;
        logic        [1:0]  reduce_op;
        logic        [2:0]  elem_count;
        logic signed [31:0] data_word0;
        logic signed [31:0] data_word1;
        logic signed [31:0] data_word2;
        logic signed [31:0] data_word3;
    } iagg_in_t;

    typedef struct packed {
        logic        [2:0]  status;
        logic        [2:0]  out_port;
        logic        [9:0]  out_dest_node;
        logic        [1:0]  out_op;
        logic        [2:0]  out_count;
        logic signed [31:0] out_word0;
        logic signed [31:0] out_word1;
        logic signed [31:0] out_word2;
        logic signed [31:0] out_word3;
    } iagg_out_t;

    // A classified item as it waits between the front and the back end.
    typedef struct packed {
        logic                   dir_down;
        logic                   up_from_up;
        logic                   self_dest;
        logic [TGT_W-1:0]       target;
        logic [2:0]             src;
        logic [9:0]             dest;
        logic [1:0]             op;
        logic [2:0]             count;
        logic [WORDS-1:0][31:0] data;
    } iagg_entry_t;

endpackage

`default_nettype wire

FILE: rtl/iagg_front.sv
// ----------------------------------------------------------------------------
// Aggregator front end
// Classifies each incoming item by direction and target port and pushes it
// into the queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iagg_front
    import iagg_pkg::*;
#(
    parameter int PORT_COUNT = 8,
    parameter int VECTOR_LEN = 4
)
(
    input  wire logic        in_valid,
    output logic             in_ready,
    input  iagg_in_t         in_item,
    input  wire logic [7:0]  switch_index,
    input  wire logic        q_full,
    output logic             q_push,
    output iagg_entry_t      q_entry
);

    localparam int HALF    = PORT_COUNT / 2;
    localparam int LANES   = (VECTOR_LEN < WORDS) ? VECTOR_LEN : WORDS;
    localparam int FIRST_W = 8 + $clog2(HALF + 1);
    localparam int DW      = ((FIRST_W > 10) ? FIRST_W : 10) + 1;
    localparam int PCW     = $clog2(PORT_COUNT + 1);

    logic [FIRST_W-1:0] first_node;
    logic [DW-1:0]      offset;
    logic               is_local;
    logic [TGT_W-1:0]   target;
    logic               ignore_item;

    assign first_node = FIRST_W'(switch_index) * FIRST_W'(HALF);
    assign offset     = DW'(in_item.dest_node) - DW'(first_node);
    // A clear top bit means the destination is at or above the range start.
    assign is_local   = !offset[DW-1] && (offset < DW'(HALF));
    assign target     = TGT_W'(HALF) + TGT_W'(offset);

    // Items from a port this switch does not have are dropped silently.
    assign ignore_item = (PCW'(in_item.source_port) >= PCW'(PORT_COUNT));

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && !ignore_item;

    always_comb
    begin
        q_entry            = '0;
        q_entry.dir_down   = is_local;
        q_entry.up_from_up = !is_local && (TGT_W'(in_item.source_port) < TGT_W'(HALF));
        q_entry.self_dest  = (TGT_W'(in_item.source_port) == target);
        q_entry.target     = target;
        q_entry.src        = in_item.source_port;
        q_entry.dest       = in_item.dest_node;
        q_entry.op         = in_item.reduce_op;
        q_entry.count      = (in_item.elem_count > 3'(LANES)) ? 3'(LANES)
                                                               : in_item.elem_count;
        q_entry.data[0]    = in_item.data_word0;
        q_entry.data[1]    = in_item.data_word1;
        q_entry.data[2]    = in_item.data_word2;
        q_entry.data[3]    = in_item.data_word3;
    end

endmodule

`default_nettype wire

FILE: rtl/iagg_queue.sv
// ----------------------------------------------------------------------------
// Aggregator item queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iagg_queue
    import iagg_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  iagg_entry_t push_entry,
    output logic        full,
    input  wire logic   pop,
    output logic        valid,
    output iagg_entry_t head
);

    iagg_entry_t mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign valid = (fill_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/iagg_back.sv
// ----------------------------------------------------------------------------
// Aggregator back end
// Checks each classified item against the reduction state, combines it into
// the accumulator and releases results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iagg_back
    import iagg_pkg::*;
#(
    parameter int PORT_COUNT = 8,
    parameter int VECTOR_LEN = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] switch_index,
    input  wire logic       q_valid,
    input  iagg_entry_t     q_head,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output iagg_out_t       out_item
);

    localparam int HALF   = PORT_COUNT / 2;
    localparam int DOWN_N = PORT_COUNT - HALF;
    localparam int LANES  = (VECTOR_LEN < WORDS) ? VECTOR_LEN : WORDS;
    localparam int RECIP  = (65536 + HALF - 1) / HALF;
    localparam logic [DOWN_N-1:0] UP_FULL = DOWN_N'((1 << HALF) - 1);

    typedef enum logic [1:0] {
        ST_EXEC   = 2'b01,
        ST_COMMIT = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        ACT_ERROR,
        ACT_START,
        ACT_MERGE,
        ACT_RELEASE
    } action_t;

    function automatic logic [31:0] combine(input logic [31:0] a, input logic [31:0] b,
                                            input logic [1:0] op);
        logic [31:0] r;
        case (iagg_op_t'(op))
            OP_SUM:  r = a + b;
            OP_PROD: r = a * b;
            OP_MIN:  r = ($signed(a) <= $signed(b)) ? a : b;
            OP_MAX:  r = ($signed(a) >= $signed(b)) ? a : b;
            default: r = a;
        endcase
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic                   up_active_reg, down_active_reg;
    logic [DOWN_N-1:0]      up_arr_reg;
    logic [PORT_COUNT-1:0]  down_arr_reg;
    logic [9:0]             held_dest_reg;
    logic [1:0]             held_op_reg;
    logic [2:0]             held_count_reg;
    logic [31:0]            acc_reg [LANES];

    action_t                act_reg, act_next;
    iagg_status_t           status_reg, status_next;
    logic [PORT_COUNT-1:0]  mask_reg, mask_next;
    logic                   down_reg;
    logic [TGT_W-1:0]       target_reg;
    logic [9:0]             dest_reg;
    logic [1:0]             op_reg;
    logic [2:0]             count_reg;
    logic [31:0]            lane_reg [LANES];
    logic [31:0]            lane_next [LANES];

    logic                   out_valid_reg;
    iagg_out_t              out_item_reg, out_item_next;

    logic [PORT_COUNT-1:0]  down_mask;
    logic [DOWN_N-1:0]      up_mask;
    logic [PORT_COUNT-1:0]  down_miss;
    logic                   down_last;
    logic                   emit;
    logic                   commit;
    logic [24:0]            recip_prod;
    logic [7:0]             up_quot;
    logic [7:0]             up_port;
    logic [31:0]            words_out [WORDS];

    assign down_mask = PORT_COUNT'(1) << q_head.src;
    assign up_mask   = DOWN_N'(1) << (TGT_W'(q_head.src) - TGT_W'(HALF));
    assign down_miss = ~(down_arr_reg | down_mask);
    // Exactly one port still missing: the destination's own down-port.
    assign down_last = (down_miss != '0) && ((down_miss & (down_miss - PORT_COUNT'(1))) == '0);

    // Check the head item against the current reduction state.
    always_comb
    begin
        act_next    = ACT_ERROR;
        status_next = STATUS_RELEASED;
        mask_next   = down_mask;
        if (!q_head.dir_down)
        begin
            mask_next = PORT_COUNT'(up_mask);
            if (q_head.up_from_up)
                status_next = STATUS_WRONG_DIR;
            else if (down_active_reg)
                status_next = STATUS_CONFLICT;
            else if (!up_active_reg)
                act_next = ACT_START;
            else if ((up_arr_reg & up_mask) != '0)
                status_next = STATUS_DUPLICATE;
            else if (held_dest_reg != q_head.dest)
                status_next = STATUS_DEST;
            else if (held_op_reg != q_head.op)
                status_next = STATUS_OP;
            else if (held_count_reg != q_head.count)
                status_next = STATUS_LENGTH;
            else if ((up_arr_reg | up_mask) == UP_FULL)
                act_next = ACT_RELEASE;
            else
                act_next = ACT_MERGE;
        end
        else
        begin
            if (up_active_reg)
                status_next = STATUS_CONFLICT;
            else if (!down_active_reg)
            begin
                if (q_head.self_dest)
                    status_next = STATUS_SELF;
                else
                    act_next = ACT_START;
            end
            else if ((down_arr_reg & down_mask) != '0)
                status_next = STATUS_DUPLICATE;
            else if (held_dest_reg != q_head.dest)
                status_next = STATUS_DEST;
            else if (q_head.self_dest)
                status_next = STATUS_SELF;
            else if (held_op_reg != q_head.op)
                status_next = STATUS_OP;
            else if (held_count_reg != q_head.count)
                status_next = STATUS_LENGTH;
            else if (down_last)
                act_next = ACT_RELEASE;
            else
                act_next = ACT_MERGE;
        end
    end

    // One combine unit per lane; a fresh reduction loads the item's words.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (act_next == ACT_START)
                lane_next[i] = (3'(i) < q_head.count) ? q_head.data[i] : 32'd0;
            else if (3'(i) < held_count_reg)
                lane_next[i] = combine(acc_reg[i], q_head.data[i], held_op_reg);
            else
                lane_next[i] = acc_reg[i];
        end
    end

    // Up-port is the switch index modulo half the port count.
    assign recip_prod = 25'(switch_index) * 25'(RECIP);
    assign up_quot    = recip_prod[23:16];
    assign up_port    = switch_index - 8'(12'(up_quot) * 12'(HALF));

    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            words_out[i] = 32'd0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (3'(i) < held_count_reg)
                words_out[i] = lane_reg[i];
        end
    end

    assign emit   = (act_reg == ACT_ERROR) || (act_reg == ACT_RELEASE);
    assign commit = (state_reg == ST_COMMIT) && (!emit || !out_valid_reg || out_ready);
    assign q_pop  = (state_reg == ST_EXEC) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (q_valid)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit)
                    state_next = ST_EXEC;
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_comb
    begin
        out_item_next = '0;
        if (act_reg == ACT_ERROR)
        begin
            out_item_next.status = status_reg;
        end
        else
        begin
            out_item_next.status        = STATUS_RELEASED;
            out_item_next.out_port      = down_reg ? target_reg[2:0] : up_port[2:0];
            out_item_next.out_dest_node = held_dest_reg;
            out_item_next.out_op        = held_op_reg;
            out_item_next.out_count     = held_count_reg;
            out_item_next.out_word0     = words_out[0];
            out_item_next.out_word1     = words_out[1];
            out_item_next.out_word2     = words_out[2];
            out_item_next.out_word3     = words_out[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_EXEC;
            up_active_reg   <= 1'b0;
            down_active_reg <= 1'b0;
            up_arr_reg      <= '0;
            down_arr_reg    <= '0;
            act_reg         <= ACT_ERROR;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                act_reg <= act_next;
            end
            if (commit)
            begin
                case (act_reg)
                    ACT_START:
                    begin
                        if (down_reg)
                        begin
                            down_active_reg <= 1'b1;
                            down_arr_reg    <= mask_reg;
                        end
                        else
                        begin
                            up_active_reg <= 1'b1;
                            up_arr_reg    <= DOWN_N'(mask_reg);
                        end
                    end
                    ACT_MERGE:
                    begin
                        if (down_reg)
                            down_arr_reg <= down_arr_reg | mask_reg;
                        else
                            up_arr_reg <= up_arr_reg | DOWN_N'(mask_reg);
                    end
                    ACT_RELEASE:
                    begin
                        up_active_reg   <= 1'b0;
                        down_active_reg <= 1'b0;
                        up_arr_reg      <= '0;
                        down_arr_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (commit && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            mask_reg   <= mask_next;
            down_reg   <= q_head.dir_down;
            target_reg <= q_head.target;
            dest_reg   <= q_head.dest;
            op_reg     <= q_head.op;
            count_reg  <= q_head.count;
            lane_reg   <= lane_next;
        end
        if (commit)
        begin
            if (act_reg == ACT_START)
            begin
                held_dest_reg  <= dest_reg;
                held_op_reg    <= op_reg;
                held_count_reg <= count_reg;
            end
            if (act_reg != ACT_ERROR)
                acc_reg <= lane_reg;
        end
        if (commit && emit)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

FILE: rtl/in_network_reduce_aggregator.sv
// ----------------------------------------------------------------------------
// In-network reduce aggregator
// Edge-switch reduce combiner: checks reduce items per port and releases one
// element-wise reduced item once every required port has arrived.
// ----------------------------------------------------------------------------
// Flow: an accepted item reaches the back end through a two-entry queue; the
// back end checks it in its exec state, commits state and any result in its
// commit state (held while a finished result waits), and only then takes the
// next item, as both steps use the shared accumulator and arrival flags.
// Reset: rst_n clears the switch index, the reduction flags, the queue and
// the output valid flag; the accumulator holds no value until a reduction starts.
`default_nettype none

module in_network_reduce_aggregator
    import iagg_pkg::*;
#(
    parameter int PORT_COUNT = 8,
    parameter int VECTOR_LEN = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  iagg_in_t        in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output iagg_out_t       out_item
);

    // The switch index sets the local node range and the up-port used for
    // releases. The user must write it only while the block is idle; unenforced.
    logic [7:0]  switch_index_reg;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    iagg_entry_t q_entry;
    iagg_entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_index_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            switch_index_reg <= cfg_wr_data;
        end
    end

    // The front end decides the direction of each item and its target
    // down-port, drops items from ports that do not exist, and queues the rest.
    iagg_front #(
        .PORT_COUNT (PORT_COUNT),
        .VECTOR_LEN (VECTOR_LEN)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .switch_index (switch_index_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (q_entry)
    );

    // The queue lets the front keep taking items while the back end waits
    // on a stalled output.
    iagg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // The back end checks each item in its exec state, registering the lane
    // results, and commits the state and any result in its commit state.
    iagg_back #(
        .PORT_COUNT (PORT_COUNT),
        .VECTOR_LEN (VECTOR_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .switch_index (switch_index_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item)
    );

endmodule

`default_nettype wire

FILE: sim/tb_in_network_reduce_aggregator.sv
// ----------------------------------------------------------------------------
// Reduce aggregator testbench
// Drives reduce items into the edge-switch combiner under random bursts and
// output stalls, predicts every status and released item with a model of its
// own, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_in_network_reduce_aggregator;
    import iagg_pkg::*;

    // Block configuration; the predictor works at the same sizes.
    localparam int PORT_COUNT = 8;
    localparam int VECTOR_LEN = 4;
    localparam int HALF_PORTS = PORT_COUNT / 2;
    localparam int LANES      = WORDS;

    // Stimulus sizes and run limits.
    localparam int DIRECTED_ITEMS = 27;
    localparam int RANDOM_ITEMS   = 1150;
    // Cycles to let pass once the last expected result is in: the block may
    // still hold two items queued and one in its back end.
    localparam int SETTLE_CYCLES  = 12;
    // Longest legal quiet stretch is a few settle pauses plus a config write,
    // far below this.
    localparam int QUIET_LIMIT    = 4000;

    logic      clk;
    logic      rst_n       = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic      in_valid    = 1'b0;
    logic      in_ready;
    iagg_in_t  in_item     = '0;
    logic      out_valid;
    logic      out_ready   = 1'b0;
    iagg_out_t out_item;

    in_network_reduce_aggregator #(
        .PORT_COUNT (PORT_COUNT),
        .VECTOR_LEN (VECTOR_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    // 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Predictor state. This is the testbench's own copy of the switch index,
    // the two reduction flags, the per-port arrival masks and the accumulator.
    // ------------------------------------------------------------------------
    logic [7:0]                cfg_switch_index = '0;
    bit                        up_busy;
    bit                        down_busy;
    logic [HALF_PORTS-1:0]     up_seen;
    logic [PORT_COUNT-1:0]     down_seen;
    logic [9:0]                hold_dest;
    logic [1:0]                hold_op;
    logic [2:0]                hold_count;
    logic [LANES-1:0][31:0]    acc;

    // Items waiting for the sender, and results the block still owes us.
    iagg_in_t  message_q [$];
    iagg_out_t outcome_q [$];

    int queued_total;
    int accepted_total;
    int mismatch_count;
    int release_count;
    int error_count;
    int settings_used;
    int burst_left = 1;
    int gap_left;
    int quiet_cycles;
    int pattern_age;
    logic [7:0] stall_pattern = 8'hFF;

    // True when a destination falls inside this switch's local node range.
    function automatic bit is_local(input logic [9:0] d);
        int first_node;
        first_node = int'(cfg_switch_index) * HALF_PORTS;
        return (int'(d) >= first_node) && (int'(d) - first_node < HALF_PORTS);
    endfunction

    // One lane of the element-wise combine. Sum and product wrap at 32 bits.
    function automatic logic [31:0] lane_combine(input logic [31:0] a,
                                                 input logic [31:0] b,
                                                 input logic [1:0]  op);
        case (op)
            OP_SUM:  return a + b;
            OP_PROD: return a * b;
            OP_MIN:  return ($signed(a) <= $signed(b)) ? a : b;
            default: return ($signed(a) >= $signed(b)) ? a : b;
        endcase
    endfunction

    // The released item: held header, accumulated words, zeros past the count.
    function automatic iagg_out_t released_item(input logic [2:0] port);
        iagg_out_t r;
        logic [LANES-1:0][31:0] w;
        int i;
        r = '0;
        for (i = 0; i < LANES; i++)
            w[i] = (i < int'(hold_count)) ? acc[i] : 32'd0;
        r.status        = STATUS_RELEASED;
        r.out_port      = port;
        r.out_dest_node = hold_dest;
        r.out_op        = hold_op;
        r.out_count     = hold_count;
        r.out_word0     = w[0];
        r.out_word1     = w[1];
        r.out_word2     = w[2];
        r.out_word3     = w[3];
        return r;
    endfunction

    // The first item of a reduction loads the header and the accumulator.
    task automatic hold_first(input iagg_in_t m, input int sat,
                              input logic [LANES-1:0][31:0] w);
        int i;
        hold_dest  = m.dest_node;
        hold_op    = m.reduce_op;
        hold_count = 3'(sat);
        for (i = 0; i < LANES; i++)
            acc[i] = (i < sat) ? w[i] : 32'd0;
    endtask

    task automatic fold_in(input logic [LANES-1:0][31:0] w);
        int i;
        for (i = 0; i < LANES && i < int'(hold_count); i++)
            acc[i] = lane_combine(acc[i], w[i], hold_op);
    endtask

    // Apply one accepted item to the predictor and queue the result it causes,
    // if any. Errors leave the reduction state exactly as it was.
    task automatic absorb_message(input iagg_in_t m);
        int sat;
        int first_node;
        int tgt;
        bit emit;
        iagg_out_t res;
        logic [LANES-1:0][31:0] w;
        logic [HALF_PORTS-1:0] up_bit;
        logic [PORT_COUNT-1:0] down_bit;
        emit = 1'b0;
        res  = '0;
        w    = {m.data_word3, m.data_word2, m.data_word1, m.data_word0};
        // Counts above the vector length are clipped; zero is an empty vector.
        sat = int'(m.elem_count);
        if (sat > VECTOR_LEN)
            sat = VECTOR_LEN;
        if (sat > LANES)
            sat = LANES;
        first_node = int'(cfg_switch_index) * HALF_PORTS;
        if (int'(m.source_port) >= PORT_COUNT)
            return;

        if (!is_local(m.dest_node))
        begin
            // Upward: only down-ports may contribute.
            if (int'(m.source_port) < HALF_PORTS)
            begin
                res.status = STATUS_WRONG_DIR;
                emit = 1'b1;
            end
            else if (down_busy)
            begin
                res.status = STATUS_CONFLICT;
                emit = 1'b1;
            end
            else
            begin
                up_bit = '0;
                up_bit[int'(m.source_port) - HALF_PORTS] = 1'b1;
                if (!up_busy)
                begin
                    hold_first(m, sat, w);
                    up_busy = 1'b1;
                    up_seen = up_bit;
                end
                else if ((up_seen & up_bit) != '0)
                begin
                    res.status = STATUS_DUPLICATE;
                    emit = 1'b1;
                end
                else if (hold_dest != m.dest_node)
                begin
                    res.status = STATUS_DEST;
                    emit = 1'b1;
                end
                else if (hold_op != m.reduce_op)
                begin
                    res.status = STATUS_OP;
                    emit = 1'b1;
                end
                else if (int'(hold_count) != sat)
                begin
                    res.status = STATUS_LENGTH;
                    emit = 1'b1;
                end
                else
                begin
                    fold_in(w);
                    up_seen = up_seen | up_bit;
                    if (up_seen == '1)
                    begin
                        // Leaves on the up-port in the same column as the switch.
                        res = released_item(3'(int'(cfg_switch_index) % HALF_PORTS));
                        emit = 1'b1;
                        up_busy = 1'b0;
                        up_seen = '0;
                    end
                end
            end
        end
        else
        begin
            // Downward: every port but the destination's own down-port.
            tgt = HALF_PORTS + int'(m.dest_node) - first_node;
            if (up_busy)
            begin
                res.status = STATUS_CONFLICT;
                emit = 1'b1;
            end
            else
            begin
                down_bit = '0;
                down_bit[m.source_port] = 1'b1;
                if (!down_busy)
                begin
                    if (int'(m.source_port) == tgt)
                    begin
                        res.status = STATUS_SELF;
                        emit = 1'b1;
                    end
                    else
                    begin
                        hold_first(m, sat, w);
                        down_busy = 1'b1;
                        down_seen = down_bit;
                    end
                end
                else if ((down_seen & down_bit) != '0)
                begin
                    res.status = STATUS_DUPLICATE;
                    emit = 1'b1;
                end
                else if (hold_dest != m.dest_node)
                begin
                    res.status = STATUS_DEST;
                    emit = 1'b1;
                end
                else if (int'(m.source_port) == tgt)
                begin
                    res.status = STATUS_SELF;
                    emit = 1'b1;
                end
                else if (hold_op != m.reduce_op)
                begin
                    res.status = STATUS_OP;
                    emit = 1'b1;
                end
                else if (int'(hold_count) != sat)
                begin
                    res.status = STATUS_LENGTH;
                    emit = 1'b1;
                end
                else
                begin
                    fold_in(w);
                    down_seen = down_seen | down_bit;
                    if ($countones(down_seen) == PORT_COUNT - 1)
                    begin
                        res = released_item(3'(tgt));
                        emit = 1'b1;
                        down_busy = 1'b0;
                        down_seen = '0;
                    end
                end
            end
        end
        if (emit)
            outcome_q.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Data words lean toward the values where wrap and sign matter.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'h0000_0001;
            5:       return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    function automatic iagg_in_t make_message(input int src, input int dest,
                                              input logic [1:0] op, input int cnt);
        iagg_in_t m;
        m.source_port = 3'(src);
        m.dest_node   = 10'(dest);
        m.reduce_op   = op;
        m.elem_count  = 3'(cnt);
        m.data_word0  = random_word();
        m.data_word1  = random_word();
        m.data_word2  = random_word();
        m.data_word3  = random_word();
        return m;
    endfunction

    // A raw count that clips to the wanted length; a full vector may be sent
    // as any count at or above it.
    function automatic int raw_count(input int sat);
        if (sat >= VECTOR_LEN)
            return $urandom_range(VECTOR_LEN, 7);
        return sat;
    endfunction

    // A destination outside the local range, with the node extremes often.
    function automatic logic [9:0] remote_dest();
        logic [9:0] d;
        do
        begin
            case ($urandom_range(0, 7))
                0:       d = '0;
                1:       d = '1;
                default: d = 10'($urandom_range(0, 1023));
            endcase
        end
        while (is_local(d));
        return d;
    endfunction

    task automatic post(input iagg_in_t m);
        message_q.push_back(m);
        queued_total++;
    endtask

    // One well-formed reduction with random content. Now and then a broken
    // item is slipped in between the good ones; since errors do not touch the
    // state, the reduction still completes. A rare fully random item is noise.
    task automatic queue_reduction(input bit downward);
        int first_node;
        int k;
        int i;
        int j;
        int t;
        int n;
        int sat;
        int ports [PORT_COUNT];
        logic [9:0] dest;
        logic [9:0] alt;
        logic [1:0] op;
        iagg_in_t m;
        first_node = int'(cfg_switch_index) * HALF_PORTS;
        k = $urandom_range(0, HALF_PORTS - 1);
        n = 0;
        if (downward)
        begin
            dest = 10'(first_node + k);
            for (i = 0; i < PORT_COUNT; i++)
                if (i != HALF_PORTS + k)
                begin
                    ports[n] = i;
                    n++;
                end
        end
        else
        begin
            dest = remote_dest();
            for (i = HALF_PORTS; i < PORT_COUNT; i++)
            begin
                ports[n] = i;
                n++;
            end
        end
        for (i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ports[i];
            ports[i] = ports[j];
            ports[j] = t;
        end
        op  = 2'($urandom_range(0, 3));
        sat = ($urandom_range(0, 3) == 0) ? $urandom_range(0, VECTOR_LEN)
                                          : $urandom_range(1, VECTOR_LEN);

        // A downward reduction opened from the destination's own port.
        if (downward && $urandom_range(0, 7) == 0)
            post(make_message(HALF_PORTS + k, int'(dest), op, raw_count(sat)));

        for (i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < 12)
            begin
                m = make_message(ports[i], int'(dest), op, raw_count(sat));
                case ($urandom_range(0, 6))
                    0:
                    begin
                        m.source_port = 3'($urandom_range(0, HALF_PORTS - 1));
                        m.dest_node   = remote_dest();
                    end
                    1:
                    begin
                        if (downward)
                        begin
                            m.source_port = 3'($urandom_range(HALF_PORTS, PORT_COUNT - 1));
                            m.dest_node   = remote_dest();
                        end
                        else
                        begin
                            m.source_port = 3'($urandom_range(0, PORT_COUNT - 1));
                            m.dest_node   = 10'(first_node + $urandom_range(0, HALF_PORTS - 1));
                        end
                    end
                    2:
                        m.source_port = 3'(ports[$urandom_range(0, i - 1)]);
                    3:
                    begin
                        if (downward)
                            m.dest_node = 10'(first_node
                                + (k + $urandom_range(1, HALF_PORTS - 1)) % HALF_PORTS);
                        else
                        begin
                            do
                                alt = remote_dest();
                            while (alt == dest);
                            m.dest_node = alt;
                        end
                    end
                    4:
                        m.reduce_op = op ^ 2'($urandom_range(1, 3));
                    5:
                        m.elem_count = 3'(raw_count((sat + $urandom_range(1, VECTOR_LEN))
                                                    % (VECTOR_LEN + 1)));
                    default:
                    begin
                        if (downward)
                            m.source_port = 3'(HALF_PORTS + k);
                        else
                            m.reduce_op = op ^ 2'd1;
                    end
                endcase
                post(m);
            end
            post(make_message(ports[i], int'(dest), op, raw_count(sat)));
            if ($urandom_range(0, 99) < 2)
                post(make_message($urandom_range(0, PORT_COUNT - 1), $urandom_range(0, 1023),
                                  2'($urandom_range(0, 3)), $urandom_range(0, 7)));
        end
    endtask

    // Noise can leave a reduction half done. With the block idle, the
    // predictor's own state tells which ports are still missing; send them
    // so that the next batch starts from a clean switch.
    task automatic close_open_reduction();
        int i;
        int tgt;
        if (up_busy)
        begin
            for (i = 0; i < HALF_PORTS; i++)
                if (!up_seen[i])
                    post(make_message(HALF_PORTS + i, int'(hold_dest), hold_op,
                                      int'(hold_count)));
        end
        else if (down_busy)
        begin
            tgt = HALF_PORTS + int'(hold_dest) - int'(cfg_switch_index) * HALF_PORTS;
            for (i = 0; i < PORT_COUNT; i++)
                if (!down_seen[i] && i != tgt)
                    post(make_message(i, int'(hold_dest), hold_op, int'(hold_count)));
        end
    endtask

    // Idle means every queued item accepted and every expected result seen.
    // Items that cause no result may still be inside, so a settle pause
    // follows.
    task automatic wait_until_drained();
        while (accepted_total != queued_total || outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle. The predictor copy changes at the
    // same edge the register does; no item can be accepted before the next.
    task automatic write_switch_index(input logic [7:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_switch_index = v;
        settings_used++;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t mismatch on %0s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_outcome(input iagg_out_t got, input iagg_out_t want);
        if (got.status !== want.status)
            flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.out_port !== want.out_port)
            flag_mismatch("out_port", 32'(got.out_port), 32'(want.out_port));
        if (got.out_dest_node !== want.out_dest_node)
            flag_mismatch("out_dest_node", 32'(got.out_dest_node), 32'(want.out_dest_node));
        if (got.out_op !== want.out_op)
            flag_mismatch("out_op", 32'(got.out_op), 32'(want.out_op));
        if (got.out_count !== want.out_count)
            flag_mismatch("out_count", 32'(got.out_count), 32'(want.out_count));
        if (got.out_word0 !== want.out_word0)
            flag_mismatch("out_word0", got.out_word0, want.out_word0);
        if (got.out_word1 !== want.out_word1)
            flag_mismatch("out_word1", got.out_word1, want.out_word1);
        if (got.out_word2 !== want.out_word2)
            flag_mismatch("out_word2", got.out_word2, want.out_word2);
        if (got.out_word3 !== want.out_word3)
            flag_mismatch("out_word3", got.out_word3, want.out_word3);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Items go out in bursts of random length separated by random
    // gaps, some gaps of zero length so that long back-to-back stretches
    // occur. The predictor runs at the edge where an item is accepted, so its
    // order is the block's order by construction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : sender
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_message(in_item);
                accepted_total++;
            end
            // A new item may be presented only once the current one is gone;
            // otherwise valid and the payload hold.
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (message_q.size() != 0)
                begin
                    in_item  <= message_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. out_ready follows a rotating eight-bit pattern that is picked
    // anew at random intervals: always ready, sparse, the fixed 5A mix, or a
    // random mix. Every accepted result is checked against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        iagg_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    flag_mismatch("unexpected item, status", 32'(out_item.status), 32'd0);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_outcome(out_item, want);
                    if (want.status == STATUS_RELEASED)
                        release_count++;
                    else
                        error_count++;
                end
            end
            if (pattern_age == 0)
            begin
                pattern_age = $urandom_range(16, 96);
                case ($urandom_range(0, 4))
                    0:       stall_pattern = 8'hFF;
                    1:       stall_pattern = 8'h01;
                    2:       stall_pattern = 8'h5A;
                    default: stall_pattern = 8'($urandom_range(1, 255));
                endcase
            end
            else
            begin
                pattern_age--;
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            out_ready <= stall_pattern[0];
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t no item moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: a directed part at switch index 0 (local nodes 0 to 3, which
    // sit on down-ports 4 to 7), then random batches, each under its own
    // switch index.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        iagg_in_t   m;
        int         i;
        logic [7:0] next_index;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_switch_index(8'd0);

        // Upward sum toward node 1023. The good words overflow both ways.
        // Between them: an up-port source, a repeated port, a different
        // destination, a different op and a different length.
        m = make_message(4, 1023, OP_SUM, 4);
        m.data_word0 = 32'h7fff_ffff;
        m.data_word1 = 32'h8000_0000;
        m.data_word2 = 32'hffff_ffff;
        m.data_word3 = 32'h0000_0000;
        post(m);
        post(make_message(2, 1023, OP_SUM, 4));
        post(make_message(4, 1023, OP_SUM, 4));
        post(make_message(5, 1022, OP_SUM, 4));
        post(make_message(5, 1023, OP_PROD, 4));
        post(make_message(5, 1023, OP_SUM, 2));
        m = make_message(5, 1023, OP_SUM, 4);
        m.data_word0 = 32'h0000_0001;
        m.data_word1 = 32'h8000_0000;
        m.data_word2 = 32'h0000_0001;
        m.data_word3 = 32'h8000_0000;
        post(m);
        post(make_message(6, 1023, OP_SUM, 4));
        post(make_message(7, 1023, OP_SUM, 4));

        // Downward product toward node 3, whose own port is 7. It is first
        // opened from port 7 itself, then an upward item collides with it,
        // and port 7 tries again midway. Counts above four clip to four.
        post(make_message(7, 3, OP_PROD, 7));
        m = make_message(0, 3, OP_PROD, 7);
        m.data_word0 = 32'h8000_0000;
        m.data_word1 = 32'hffff_ffff;
        m.data_word2 = 32'h7fff_ffff;
        m.data_word3 = 32'h0000_0002;
        post(m);
        post(make_message(4, 600, OP_PROD, 4));
        for (i = 1; i < 7; i++)
        begin
            if (i == 3)
                post(make_message(7, 3, OP_PROD, 4));
            post(make_message(i, 3, OP_PROD, 4 + i % 4));
        end

        // Upward minimum over an empty vector, then upward maximum of one word.
        for (i = 4; i < 8; i++)
            post(make_message(i, 512, OP_MIN, 0));
        for (i = 7; i >= 4; i--)
            post(make_message(i, 4, OP_MAX, 1));

        // Random batches; each one starts from an idle, clean switch.
        while (queued_total < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            wait_until_drained();
            close_open_reduction();
            wait_until_drained();
            case (settings_used)
                1:       next_index = 8'd255;
                2:       next_index = 8'd1;
                3:       next_index = 8'd3;
                4:       next_index = 8'd128;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       next_index = 8'd0;
                        1:       next_index = 8'd255;
                        default: next_index = 8'($urandom_range(0, 255));
                    endcase
                end
            endcase
            write_switch_index(next_index);
            repeat ($urandom_range(3, 8))
                queue_reduction(1'($urandom_range(0, 1)));
        end

        wait_until_drained();
        close_open_reduction();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            flag_mismatch("results never delivered", 32'(outcome_q.size()), 32'd0);

        $display("covered %0d items under %0d switch index settings", accepted_total,
                 settings_used);
        $display("checked %0d released items and %0d error results", release_count,
                 error_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
